@@ src/thc_pkg.sv @@
// Shared types and constants of the terrain height colorizer.
package thc_pkg;

    localparam int unsigned HEIGHT_W   = 7;
    localparam int unsigned NUM_W      = 15;
    localparam int unsigned QUO_W      = 8;
    localparam int unsigned CHAN_W     = 8;
    localparam int unsigned SCHAN_W    = 11;
    localparam int unsigned DIM_MUL_W  = 16;
    localparam int unsigned DIM_PROD_W = CHAN_W + DIM_MUL_W;

    localparam logic [HEIGHT_W-1:0]  HEIGHT_MAX = 7'd100;
    localparam logic [HEIGHT_W-1:0]  DEEP_MAX   = 7'd5;
    localparam logic [DIM_MUL_W-1:0] DIM_MUL    = 16'd55709;

    typedef enum logic [2:0] {
        BAND_DEEP,
        BAND_SHALLOW,
        BAND_SAND,
        BAND_GRASS,
        BAND_ROCK,
        BAND_SNOW
    } t_band;

endpackage

@@ src/terrain_height_colorizer.sv @@
// Top level of the terrain height colorizer: a five-stage pipeline from height sample to RGB.
// Each height sample passes five register stages before its color appears on the output. A new
// sample is accepted every cycle while the output side is ready. The stages are the band
// decision, two division stages that form the grey level, the band color with saturation, and
// the dimming multiply at the end.
// A stalled output freezes the whole pipeline. The peak height register should be written
// only while no transaction is in flight; it takes effect on the next accepted sample.
module terrain_height_colorizer (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [15:0] i_s_tdata,   // height [6:0], left_height [13:7], zero [15:14]
    input  logic [0:0]  i_s_tuser,   // has_left [0]
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [23:0] o_m_tdata,   // red [7:0], green [15:8], blue [23:16]
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [6:0]  i_cfg_data   // peak_height [6:0]
);

    localparam int unsigned HW = thc_pkg::HEIGHT_W;
    localparam int unsigned CW = thc_pkg::CHAN_W;
    localparam int unsigned SW = thc_pkg::SCHAN_W;

    logic [HW-1:0] r_peak;

    logic r_s1_valid, r_s2_valid, r_s3_valid, r_s4_valid, r_s5_valid;

    logic [thc_pkg::NUM_W-1:0] r_s1_num;
    logic [HW-1:0]             r_s1_den;
    thc_pkg::t_band            r_s1_band, r_s2_band, r_s3_band;
    logic                      r_s1_dim, r_s2_dim, r_s3_dim, r_s4_dim;
    logic [CW-1:0]             r_s4_red, r_s4_green, r_s4_blue;
    logic [CW-1:0]             r_s5_red, r_s5_green, r_s5_blue;

    logic                      w_adv;
    logic [HW-1:0]             w_height;
    logic [HW-1:0]             w_left;
    logic [HW-1:0]             w_peak;
    logic [thc_pkg::QUO_W-1:0] w_quo;

    logic [thc_pkg::NUM_W-1:0] n_s1_num;
    thc_pkg::t_band            n_s1_band;
    logic                      n_s1_dim;
    logic [CW-1:0]             n_s4_red, n_s4_green, n_s4_blue;
    logic [CW-1:0]             n_s5_red, n_s5_green, n_s5_blue;

    function automatic logic [CW-1:0] clamp8(input logic signed [SW-1:0] c);
        logic [CW-1:0] res;
        if (c < 0) begin
            res = '0;
        end else if (c > $signed(SW'(255))) begin
            res = '1;
        end else begin
            res = c[CW-1:0];
        end
        return res;
    endfunction

    function automatic logic [CW-1:0] dim8(input logic [CW-1:0] c);
        logic [thc_pkg::DIM_PROD_W-1:0] prod;
        prod = {{thc_pkg::DIM_MUL_W{1'b0}}, c} * {{CW{1'b0}}, thc_pkg::DIM_MUL};
        return prod[thc_pkg::DIM_PROD_W-1:thc_pkg::DIM_MUL_W];
    endfunction

    assign w_adv       = !r_s5_valid || i_m_tready;
    assign o_s_tready  = w_adv;
    assign o_cfg_ready = 1'b1;
    assign o_m_tvalid  = r_s5_valid;
    assign o_m_tdata   = {r_s5_blue, r_s5_green, r_s5_red};

    assign w_height = i_s_tdata[HW-1:0];
    assign w_left   = i_s_tdata[2*HW-1:HW];
    assign w_peak   = (r_peak == '0) ? HW'(1) : r_peak;

    always_comb begin
        logic [HW+3:0] h10, h5, h2, p9, p;
        h10 = {4'b0, w_height} * 11'd10;
        h5  = {4'b0, w_height} * 11'd5;
        h2  = {4'b0, w_height} << 1;
        p   = {4'b0, w_peak};
        p9  = {4'b0, w_peak} * 11'd9;
        n_s1_num = ({8'b0, w_height} << 8) - {8'b0, w_height};
        n_s1_dim = i_s_tuser[0] && (w_left > w_height);
        if (w_height <= thc_pkg::DEEP_MAX) begin
            n_s1_band = thc_pkg::BAND_DEEP;
        end else if (h10 <= p) begin
            n_s1_band = thc_pkg::BAND_SHALLOW;
        end else if (h5 <= p) begin
            n_s1_band = thc_pkg::BAND_SAND;
        end else if (h2 <= p) begin
            n_s1_band = thc_pkg::BAND_GRASS;
        end else if (h10 <= p9) begin
            n_s1_band = thc_pkg::BAND_ROCK;
        end else begin
            n_s1_band = thc_pkg::BAND_SNOW;
        end
    end

    thc_div u_div (
        .i_clk (i_clk),
        .i_en  (w_adv),
        .i_num (r_s1_num),
        .i_den (r_s1_den),
        .o_quo (w_quo)
    );

    always_comb begin
        logic signed [SW-1:0] v;
        logic signed [SW-1:0] r, g, b;
        v = $signed({{(SW - thc_pkg::QUO_W){1'b0}}, w_quo});
        case (r_s3_band)
            thc_pkg::BAND_DEEP: begin
                r = '0;
                g = '0;
                b = SW'(40);
            end
            thc_pkg::BAND_SHALLOW: begin
                r = v - SW'(10);
                g = v - SW'(10);
                b = v + SW'(40);
            end
            thc_pkg::BAND_SAND: begin
                r = v + SW'(120);
                g = v + SW'(80);
                b = v + SW'(40);
            end
            thc_pkg::BAND_GRASS: begin
                r = v - SW'(10);
                g = v + SW'(20);
                b = v - SW'(10);
            end
            thc_pkg::BAND_ROCK: begin
                r = v - SW'(40);
                g = v - SW'(50);
                b = v - SW'(40);
            end
            default: begin
                r = SW'(255);
                g = SW'(255);
                b = SW'(255);
            end
        endcase
        n_s4_red   = clamp8(r);
        n_s4_green = clamp8(g);
        n_s4_blue  = clamp8(b);
    end

    assign n_s5_red   = r_s4_dim ? dim8(r_s4_red)   : r_s4_red;
    assign n_s5_green = r_s4_dim ? dim8(r_s4_green) : r_s4_green;
    assign n_s5_blue  = r_s4_dim ? dim8(r_s4_blue)  : r_s4_blue;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_peak     <= thc_pkg::HEIGHT_MAX;
            r_s1_valid <= 1'b0;
            r_s2_valid <= 1'b0;
            r_s3_valid <= 1'b0;
            r_s4_valid <= 1'b0;
            r_s5_valid <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                r_peak <= i_cfg_data;
            end
            if (w_adv) begin
                r_s1_valid <= i_s_tvalid;
                r_s2_valid <= r_s1_valid;
                r_s3_valid <= r_s2_valid;
                r_s4_valid <= r_s3_valid;
                r_s5_valid <= r_s4_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_s1_num   <= n_s1_num;
            r_s1_den   <= w_peak;
            r_s1_band  <= n_s1_band;
            r_s1_dim   <= n_s1_dim;
            r_s2_band  <= r_s1_band;
            r_s2_dim   <= r_s1_dim;
            r_s3_band  <= r_s2_band;
            r_s3_dim   <= r_s2_dim;
            r_s4_red   <= n_s4_red;
            r_s4_green <= n_s4_green;
            r_s4_blue  <= n_s4_blue;
            r_s4_dim   <= r_s3_dim;
            r_s5_red   <= n_s5_red;
            r_s5_green <= n_s5_green;
            r_s5_blue  <= n_s5_blue;
        end
    end

endmodule

@@ src/thc_div.sv @@
// Two-stage restoring divider that yields an eight-bit quotient of a 15-bit numerator.
module thc_div (
    input  logic                               i_clk,
    input  logic                               i_en,
    input  logic [thc_pkg::NUM_W-1:0]          i_num,
    input  logic [thc_pkg::HEIGHT_W-1:0]       i_den,
    output logic [thc_pkg::QUO_W-1:0]          o_quo
);

    logic [thc_pkg::NUM_W-1:0]    r_rem;
    logic [thc_pkg::HEIGHT_W-1:0] r_den;
    logic [3:0]                   r_quo_hi;
    logic [3:0]                   r_quo_lo;
    logic [thc_pkg::NUM_W-1:0]    n_rem;
    logic [3:0]                   n_quo_hi;
    logic [3:0]                   n_quo_lo;

    always_comb begin
        logic [thc_pkg::NUM_W-1:0] rem;
        logic [thc_pkg::NUM_W:0]   shifted;
        rem      = i_num;
        n_quo_hi = '0;
        for (int i = 0; i < 4; i++) begin
            shifted = {{(thc_pkg::NUM_W + 1 - thc_pkg::HEIGHT_W){1'b0}}, i_den} << (7 - i);
            if ({1'b0, rem} >= shifted) begin
                rem             = rem - shifted[thc_pkg::NUM_W-1:0];
                n_quo_hi[3 - i] = 1'b1;
            end
        end
        n_rem = rem;
    end

    always_comb begin
        logic [thc_pkg::NUM_W-1:0] rem;
        logic [thc_pkg::NUM_W:0]   shifted;
        rem      = r_rem;
        n_quo_lo = '0;
        for (int i = 0; i < 4; i++) begin
            shifted = {{(thc_pkg::NUM_W + 1 - thc_pkg::HEIGHT_W){1'b0}}, r_den} << (3 - i);
            if ({1'b0, rem} >= shifted) begin
                rem             = rem - shifted[thc_pkg::NUM_W-1:0];
                n_quo_lo[3 - i] = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem    <= n_rem;
            r_den    <= i_den;
            r_quo_hi <= n_quo_hi;
            o_quo    <= {r_quo_hi, n_quo_lo};
        end
    end

endmodule

@@ tb/terrain_height_colorizer_test.sv @@
// Self-checking stream testbench for the terrain height colorizer with its own color predictor.
module terrain_height_colorizer_test;

    localparam int unsigned HEIGHT_W = thc_pkg::HEIGHT_W;
    localparam int unsigned CHAN_W   = thc_pkg::CHAN_W;

    typedef struct packed {
        logic [HEIGHT_W-1:0] height;
        logic [HEIGHT_W-1:0] left_height;
        logic                has_left;
    } t_sample;

    typedef struct packed {
        logic [CHAN_W-1:0] red;
        logic [CHAN_W-1:0] green;
        logic [CHAN_W-1:0] blue;
    } t_color;

    localparam int unsigned PIPE_LATENCY = 5;
    localparam int unsigned LONG_HOLD    = 300;

    logic        i_clk       = 1'b0;
    logic        i_rst_n     = 1'b0;
    logic        i_s_tvalid  = 1'b0;
    logic        o_s_tready;
    logic [15:0] i_s_tdata   = '0;
    logic [0:0]  i_s_tuser   = '0;
    logic        o_m_tvalid;
    logic        i_m_tready  = 1'b0;
    logic [23:0] o_m_tdata;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [6:0]  i_cfg_data  = '0;

    t_sample             sample_q[$];
    t_color              color_q[$];
    t_sample             offered;
    t_color              want;
    logic [HEIGHT_W-1:0] peak_height  = thc_pkg::HEIGHT_MAX;
    int unsigned         tx_idle_pct  = 0;
    int unsigned         rx_stall_pct = 0;
    int unsigned         hold_token   = 0;
    int unsigned         hold_seen    = 0;
    int unsigned         hold_left    = 0;
    bit                  failed       = 1'b0;

    terrain_height_colorizer dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .i_s_tuser   (i_s_tuser),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic int dim_channel(int c);
        return (c * 17) / 20;
    endfunction

    function automatic logic [CHAN_W-1:0] clamp_channel(int c);
        if (c < 0) begin
            return '0;
        end
        if (c > 255) begin
            return 8'd255;
        end
        return CHAN_W'(c);
    endfunction

    function automatic t_color terrain_color(t_sample s, logic [HEIGHT_W-1:0] peak);
        int             p, h, v, r, g, b;
        thc_pkg::t_band band;
        t_color         c;
        p = (peak == 0) ? 1 : int'(peak);
        h = int'(s.height);
        v = (h * 255) / p;
        if (h <= int'(thc_pkg::DEEP_MAX)) begin
            band = thc_pkg::BAND_DEEP;
        end else if (10 * h <= p) begin
            band = thc_pkg::BAND_SHALLOW;
        end else if (5 * h <= p) begin
            band = thc_pkg::BAND_SAND;
        end else if (2 * h <= p) begin
            band = thc_pkg::BAND_GRASS;
        end else if (10 * h <= 9 * p) begin
            band = thc_pkg::BAND_ROCK;
        end else begin
            band = thc_pkg::BAND_SNOW;
        end
        case (band)
            thc_pkg::BAND_DEEP: begin
                r = 0; g = 0; b = 40;
            end
            thc_pkg::BAND_SHALLOW: begin
                r = v - 10; g = v - 10; b = v + 40;
            end
            thc_pkg::BAND_SAND: begin
                r = v + 120; g = v + 80; b = v + 40;
            end
            thc_pkg::BAND_GRASS: begin
                r = v - 10; g = v + 20; b = v - 10;
            end
            thc_pkg::BAND_ROCK: begin
                r = v - 40; g = v - 50; b = v - 40;
            end
            default: begin
                r = 255; g = 255; b = 255;
            end
        endcase
        if (s.has_left && s.left_height > s.height) begin
            r = dim_channel(r);
            g = dim_channel(g);
            b = dim_channel(b);
        end
        c.red   = clamp_channel(r);
        c.green = clamp_channel(g);
        c.blue  = clamp_channel(b);
        return c;
    endfunction

    function automatic t_sample random_sample(logic [HEIGHT_W-1:0] peak);
        t_sample     s;
        int unsigned top;
        top = (peak == 0) ? 1 : int'(peak);
        case ($urandom_range(9))
            0, 1, 2, 3, 4, 5, 6: s.height = HEIGHT_W'($urandom_range(top));
            7, 8: s.height = HEIGHT_W'($urandom_range(127));
            default: s.height = HEIGHT_W'($urandom_range(7));
        endcase
        case ($urandom_range(4))
            0, 1: s.left_height = HEIGHT_W'($urandom_range(127));
            2: s.left_height = s.height;
            default: begin
                if (s.height == 7'd127) begin
                    s.left_height = 7'd127;
                end else begin
                    s.left_height = HEIGHT_W'($urandom_range(127, int'(s.height) + 1));
                end
            end
        endcase
        s.has_left = 1'($urandom_range(1));
        return s;
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_s_tvalid <= 1'b0;
        end else begin
            if (i_s_tvalid && o_s_tready) begin
                color_q.push_back(terrain_color(offered, peak_height));
            end
            if (!i_s_tvalid || o_s_tready) begin
                if (sample_q.size() != 0 && $urandom_range(99) >= tx_idle_pct) begin
                    offered = sample_q.pop_front();
                    i_s_tdata  <= {2'b00, offered.left_height, offered.height};
                    i_s_tuser  <= offered.has_left;
                    i_s_tvalid <= 1'b1;
                end else begin
                    i_s_tvalid <= 1'b0;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_m_tready <= 1'b0;
        end else if (hold_token != hold_seen) begin
            hold_seen = hold_token;
            hold_left = LONG_HOLD;
            i_m_tready <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left = hold_left - 1;
            i_m_tready <= 1'b0;
        end else begin
            i_m_tready <= ($urandom_range(99) >= rx_stall_pct);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            if (color_q.size() == 0) begin
                $error("color transaction with none expected: %h", o_m_tdata);
                failed = 1'b1;
            end else begin
                want = color_q.pop_front();
                if (o_m_tdata[7:0] !== want.red) begin
                    $error("red: expected %0d, got %0d", want.red, o_m_tdata[7:0]);
                    failed = 1'b1;
                end
                if (o_m_tdata[15:8] !== want.green) begin
                    $error("green: expected %0d, got %0d", want.green, o_m_tdata[15:8]);
                    failed = 1'b1;
                end
                if (o_m_tdata[23:16] !== want.blue) begin
                    $error("blue: expected %0d, got %0d", want.blue, o_m_tdata[23:16]);
                    failed = 1'b1;
                end
            end
        end
    end

    task automatic wait_drained();
        while (sample_q.size() != 0 || i_s_tvalid || color_q.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (PIPE_LATENCY + 3) @(posedge i_clk);
    endtask

    task automatic write_peak(input logic [HEIGHT_W-1:0] value);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= value;
        do @(posedge i_clk); while (!(i_cfg_valid && o_cfg_ready));
        i_cfg_valid <= 1'b0;
        peak_height = value;
    endtask

    task automatic run_phase(input logic [HEIGHT_W-1:0] peak, input int unsigned tx_pct,
                             input int unsigned rx_pct, input int unsigned count,
                             input bit long_hold);
        write_peak(peak);
        tx_idle_pct  <= tx_pct;
        rx_stall_pct <= rx_pct;
        if (long_hold) begin
            hold_token <= hold_token + 1;
        end
        @(posedge i_clk);
        repeat (count) sample_q.push_back(random_sample(peak));
        wait_drained();
    endtask

    initial begin
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // The reset peak of 100 is used before any register write.
        sample_q.push_back('{7'd0,   7'd0,   1'b0});
        sample_q.push_back('{7'd5,   7'd127, 1'b1});
        sample_q.push_back('{7'd6,   7'd0,   1'b1});
        sample_q.push_back('{7'd8,   7'd127, 1'b1});
        sample_q.push_back('{7'd10,  7'd0,   1'b0});
        sample_q.push_back('{7'd11,  7'd11,  1'b1});
        sample_q.push_back('{7'd20,  7'd21,  1'b1});
        sample_q.push_back('{7'd21,  7'd0,   1'b0});
        sample_q.push_back('{7'd50,  7'd0,   1'b1});
        sample_q.push_back('{7'd51,  7'd100, 1'b1});
        sample_q.push_back('{7'd85,  7'd42,  1'b1});
        sample_q.push_back('{7'd42,  7'd85,  1'b1});
        sample_q.push_back('{7'd90,  7'd0,   1'b0});
        sample_q.push_back('{7'd91,  7'd127, 1'b1});
        sample_q.push_back('{7'd100, 7'd0,   1'b0});
        sample_q.push_back('{7'd127, 7'd0,   1'b1});
        sample_q.push_back('{7'd127, 7'd127, 1'b0});
        sample_q.push_back('{7'd3,   7'd127, 1'b0});
        wait_drained();

        run_phase(7'd0,   0,  0,  40,  1'b0);
        run_phase(7'd127, 87, 0,  100, 1'b0);
        run_phase(7'd1,   0,  87, 60,  1'b0);
        run_phase(7'd100, 38, 38, 150, 1'b0);
        run_phase(HEIGHT_W'($urandom_range(126, 2)), 0, 0, 150, 1'b0);
        run_phase(7'd37,  0,  0,  80,  1'b1);
        run_phase(HEIGHT_W'($urandom_range(126, 2)), 0,  0,  50, 1'b0);
        run_phase(HEIGHT_W'($urandom_range(126, 2)), 87, 0,  50, 1'b0);
        run_phase(HEIGHT_W'($urandom_range(126, 2)), 0,  87, 50, 1'b0);
        run_phase(HEIGHT_W'($urandom_range(126, 2)), 38, 38, 50, 1'b0);

        if (!failed) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

    initial begin
        #2000000;
        $display("*** FAILED ***");
        $finish;
    end

endmodule
